// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the prime counting sieve.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define PCS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/pcs_pkg.sv
// Package with the sizes, control word type and microprogram of the prime counting sieve.
package pcs_pkg;

	localparam int MAX_LIMIT = 65536;
	localparam int LIMIT_W   = 17;
	localparam int COUNT_W   = 13;
	localparam int ADDR_W    = $clog2(MAX_LIMIT);
	localparam int N_W       = ADDR_W + 1;
	localparam int J_W       = N_W + 1;
	localparam int S_DATA_W  = ((LIMIT_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ((COUNT_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_CLR  = 3'd1,
		ST_INIT = 3'd2,
		ST_TEST = 3'd3,
		ST_WAIT = 3'd4,
		ST_MARK = 3'd5,
		ST_NEXT = 3'd6,
		ST_DONE = 3'd7
	} step_t;

	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,
		COND_IN_VALID = 3'd1,
		COND_A_GE_N   = 3'd2,
		COND_I_GE_N   = 3'd3,
		COND_MARKED   = 3'd4,
		COND_J_GE_N   = 3'd5,
		COND_OUT_FREE = 3'd6
	} cond_t;

	typedef struct packed {
		cond_t cond;
		logic  op_when;   // operations fire when the condition equals this bit
		step_t tgt_true;
		step_t tgt_false;
		logic  load;      // latch the limit, clear count and address
		logic  clr_wr;    // write maybe-prime at the clear address, advance it
		logic  i_init;    // first candidate
		logic  rd;        // read the mark of the candidate
		logic  cnt_j;     // count the candidate and start its multiples
		logic  mark_wr;   // mark a multiple composite and step to the next
		logic  i_inc;     // next candidate
		logic  out_ld;    // load the result register
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{cond: COND_ALWAYS, op_when: 1'b1, tgt_true: ST_IDLE, tgt_false: ST_IDLE,
			default: 1'b0};
		unique case (s)
			ST_IDLE: begin
				w.cond = COND_IN_VALID; w.op_when = 1'b1;
				w.tgt_true = ST_CLR; w.tgt_false = ST_IDLE; w.load = 1'b1;
			end
			ST_CLR: begin
				w.cond = COND_A_GE_N; w.op_when = 1'b0;
				w.tgt_true = ST_INIT; w.tgt_false = ST_CLR; w.clr_wr = 1'b1;
			end
			ST_INIT: begin
				w.cond = COND_ALWAYS; w.op_when = 1'b1;
				w.tgt_true = ST_TEST; w.tgt_false = ST_TEST; w.i_init = 1'b1;
			end
			ST_TEST: begin
				w.cond = COND_I_GE_N; w.op_when = 1'b0;
				w.tgt_true = ST_DONE; w.tgt_false = ST_WAIT; w.rd = 1'b1;
			end
			ST_WAIT: begin
				w.cond = COND_MARKED; w.op_when = 1'b0;
				w.tgt_true = ST_NEXT; w.tgt_false = ST_MARK; w.cnt_j = 1'b1;
			end
			ST_MARK: begin
				w.cond = COND_J_GE_N; w.op_when = 1'b0;
				w.tgt_true = ST_NEXT; w.tgt_false = ST_MARK; w.mark_wr = 1'b1;
			end
			ST_NEXT: begin
				w.cond = COND_ALWAYS; w.op_when = 1'b1;
				w.tgt_true = ST_TEST; w.tgt_false = ST_TEST; w.i_inc = 1'b1;
			end
			ST_DONE: begin
				w.cond = COND_OUT_FREE; w.op_when = 1'b1;
				w.tgt_true = ST_IDLE; w.tgt_false = ST_DONE; w.out_ld = 1'b1;
			end
			default: begin
				w.cond = COND_ALWAYS;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/prime_count_sieve.sv
// Prime counting sieve: counts the primes strictly below a limit, one item at a time.
// A request takes one limit and returns one count of the primes below it; limits above
// 65536 are treated as 65536, and limits of 0, 1 or 2 give 0. One item is worked at a
// time by a small microprogram over a single-port 65536 x 1 mark memory, so the memory
// port sets the pace: it clears the marks below the limit, then walks each candidate
// from 2 upward, reads its mark, counts it if unmarked and writes a composite mark at
// each of its multiples below the limit. A finished count waits in an output register,
// and the next limit is taken while it waits.
`include "assert_macros.svh"

module prime_count_sieve (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pcs_pkg::S_DATA_W-1:0]  s_tdata,   // [16:0] limit
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pcs_pkg::M_DATA_W-1:0]  m_tdata    // [12:0] prime_count
);

	pcs_pkg::step_t upc_q, upc_d;
	pcs_pkg::ctrl_t cw;
	logic           cond_hit, fire;

	logic [pcs_pkg::N_W-1:0]     n_q, a_q, i_q;
	logic [pcs_pkg::J_W-1:0]     j_q;
	logic [pcs_pkg::COUNT_W-1:0] count_q, out_q;
	logic                        out_valid_q;
	logic                        rd_q;
	logic [pcs_pkg::LIMIT_W-1:0] limit;
	logic [pcs_pkg::N_W-1:0]     n_in;

	logic                        mark_mem [pcs_pkg::MAX_LIMIT];
	logic                        wr_en, wr_bit;
	logic [pcs_pkg::ADDR_W-1:0]  wr_addr;

	assign limit = s_tdata[pcs_pkg::LIMIT_W-1:0];
	assign n_in  = (32'(limit) > 32'(pcs_pkg::MAX_LIMIT)) ?
		pcs_pkg::N_W'(pcs_pkg::MAX_LIMIT) : pcs_pkg::N_W'(limit);

	always_comb begin
		cw = pcs_pkg::ucode(upc_q);
		unique case (cw.cond)
			pcs_pkg::COND_ALWAYS:   cond_hit = 1'b1;
			pcs_pkg::COND_IN_VALID: cond_hit = s_tvalid;
			pcs_pkg::COND_A_GE_N:   cond_hit = a_q >= n_q;
			pcs_pkg::COND_I_GE_N:   cond_hit = i_q >= n_q;
			pcs_pkg::COND_MARKED:   cond_hit = rd_q;
			pcs_pkg::COND_J_GE_N:   cond_hit = j_q >= pcs_pkg::J_W'(n_q);
			pcs_pkg::COND_OUT_FREE: cond_hit = !out_valid_q || m_tready;
			default:                cond_hit = 1'b1;
		endcase
		fire  = (cond_hit == cw.op_when);
		upc_d = cond_hit ? cw.tgt_true : cw.tgt_false;
	end

	assign s_tready = (cw.cond == pcs_pkg::COND_IN_VALID);

	// Clear and mark passes share the one write port.
	always_comb begin
		wr_en   = fire && (cw.clr_wr || cw.mark_wr);
		wr_bit  = cw.mark_wr;
		wr_addr = cw.mark_wr ? j_q[pcs_pkg::ADDR_W-1:0] : a_q[pcs_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mark_mem[wr_addr] <= wr_bit;
		end
		if (fire && cw.rd) begin
			rd_q <= mark_mem[i_q[pcs_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= pcs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (fire && cw.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cw.load) begin
				n_q     <= n_in;
				a_q     <= '0;
				count_q <= '0;
			end
			if (cw.clr_wr) begin
				a_q <= a_q + 1'b1;
			end
			if (cw.i_init) begin
				i_q <= pcs_pkg::N_W'(2);
			end
			if (cw.cnt_j) begin
				count_q <= count_q + 1'b1;
				j_q     <= {i_q, 1'b0};
			end
			if (cw.mark_wr) begin
				j_q <= j_q + pcs_pkg::J_W'(i_q);
			end
			if (cw.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cw.out_ld) begin
				out_q <= count_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pcs_pkg::M_DATA_W'(out_q);

	`PCS_ASSERT_IMPL(a_wr_in_range, wr_en,
		(cw.mark_wr ? j_q : pcs_pkg::J_W'(a_q)) < pcs_pkg::J_W'(n_q),
		"mark write beyond the limit")
	`PCS_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q),
		$past(upc_q == pcs_pkg::ST_DONE), "result raised outside the done step")
	`PCS_ASSERT_IMPL(a_count_bound, upc_q == pcs_pkg::ST_TEST,
		pcs_pkg::N_W'(count_q) <= i_q, "prime count exceeds candidates walked")

endmodule
